>>> src/bodq_pkg.sv
// ----------------------------------------------------------------------------
// bodq_pkg - shared types and constants for the ordered dither quantiser
// Beat payloads, the job handed from front to back, config register codes,
// the 8x8 Bayer matrix and per-depth reciprocals for the normalised output.
// ----------------------------------------------------------------------------
`default_nettype none

package bodq_pkg;

  localparam int SAMPLE_W = 18;
  localparam int LEVEL_W  = 8;
  localparam int NORM_W   = 16;
  localparam int CFG_W    = 16;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DEPTH    = 2'd0;
  localparam cfg_idx_t CFG_ROW      = 2'd1;
  localparam cfg_idx_t CFG_CHANNELS = 2'd2;

  localparam logic [4:0] DEPTH_DEFAULT = 5'd6;
  localparam logic [4:0] DEPTH_MAX     = 5'd8;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [NORM_W-1:0]  normalized;
  } out_beat_t;

  typedef struct packed {
    logic [4:0]  depth_request;
    logic [15:0] row_width;
    logic [3:0]  channel_count;
  } cfg_t;

  // one classified sample waiting for the back end
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [5:0]                 bayer;
    logic [3:0]                 bits;
  } job_t;

  localparam logic [5:0] BAYER [64] = '{
    6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
    6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
    6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
    6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
    6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
    6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
    6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
    6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
  };

  // ceil(65535 * 2^16 / (2^b - 1)); level * recip >> 16 gives the exact floor
  localparam logic [63:0] NORM_NUM = 64'd4294901760;
  localparam logic [31:0] RECIP_1 = 32'(NORM_NUM);
  localparam logic [31:0] RECIP_2 = 32'((NORM_NUM + 64'd2)   / 64'd3);
  localparam logic [31:0] RECIP_3 = 32'((NORM_NUM + 64'd6)   / 64'd7);
  localparam logic [31:0] RECIP_4 = 32'((NORM_NUM + 64'd14)  / 64'd15);
  localparam logic [31:0] RECIP_5 = 32'((NORM_NUM + 64'd30)  / 64'd31);
  localparam logic [31:0] RECIP_6 = 32'((NORM_NUM + 64'd62)  / 64'd63);
  localparam logic [31:0] RECIP_7 = 32'((NORM_NUM + 64'd126) / 64'd127);
  localparam logic [31:0] RECIP_8 = 32'((NORM_NUM + 64'd254) / 64'd255);

  function automatic logic [5:0] bayer_at(input logic [2:0] row, input logic [2:0] col);
    return BAYER[{row, col}];
  endfunction

  function automatic logic [31:0] norm_recip(input logic [3:0] bits);
    logic [31:0] r;
    unique case (bits)
      4'd1:    r = RECIP_1;
      4'd2:    r = RECIP_2;
      4'd3:    r = RECIP_3;
      4'd4:    r = RECIP_4;
      4'd5:    r = RECIP_5;
      4'd6:    r = RECIP_6;
      4'd7:    r = RECIP_7;
      default: r = RECIP_8;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/bodq_stream_if.sv
// ----------------------------------------------------------------------------
// bodq_stream_if - valid/ready stream channel
// Carries one payload beat per handshake; source drives valid and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface bodq_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/bodq_front.sv
// ----------------------------------------------------------------------------
// bodq_front - position tracking and classification
// Accepts sample beats, tracks channel/column/row phase and emits a job with
// the Bayer entry and effective bit depth for each sample.
// ----------------------------------------------------------------------------
`default_nettype none

module bodq_front #(
  parameter int MAX_WIDTH    = 65535,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  bodq_pkg::cfg_t                         cfg,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [bodq_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                                   in_frame_start,
  input  logic                                   q_full,
  output logic                                   q_push,
  output bodq_pkg::job_t                         q_job
);
  import bodq_pkg::*;

  localparam int EFF_W  = (MAX_WIDTH > 65535) ? 65535 : MAX_WIDTH;
  localparam int EFF_CH = (MAX_CHANNELS > 15) ? 15 : MAX_CHANNELS;
  localparam int COL_W  = $clog2(EFF_W + 1);
  localparam int CH_W   = $clog2(EFF_CH + 1);
  localparam logic [15:0] W_CAP  = 16'(EFF_W);
  localparam logic [3:0]  CH_CAP = 4'(EFF_CH);

  logic [COL_W-1:0] col_r, col_nxt, pos_col, col_inc;
  logic [CH_W-1:0]  ch_r, ch_nxt, pos_ch, ch_inc;
  logic [2:0]       row_r, row_nxt, pos_row;
  logic [15:0]      w_lim;
  logic [3:0]       ch_lim;
  logic [3:0]       bits;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // frame start puts this very sample at the origin
  assign pos_col = in_frame_start ? '0 : col_r;
  assign pos_ch  = in_frame_start ? '0 : ch_r;
  assign pos_row = in_frame_start ? '0 : row_r;
  assign col_inc = pos_col + 1'b1;
  assign ch_inc  = pos_ch + 1'b1;

  always_comb begin
    w_lim = (cfg.row_width == '0) ? 16'd1 : cfg.row_width;
    if (w_lim > W_CAP) begin
      w_lim = W_CAP;
    end
    ch_lim = (cfg.channel_count == '0) ? 4'd1 : cfg.channel_count;
    if (ch_lim > CH_CAP) begin
      ch_lim = CH_CAP;
    end
  end

  always_comb begin
    col_nxt = pos_col;
    row_nxt = pos_row;
    ch_nxt  = ch_inc;
    if (4'(ch_inc) >= ch_lim) begin
      ch_nxt  = '0;
      col_nxt = col_inc;
      if (16'(col_inc) >= w_lim) begin
        col_nxt = '0;
        row_nxt = pos_row + 3'd1;
      end
    end
  end

  always_comb begin
    priority if (cfg.depth_request == '0) begin
      bits = 4'(DEPTH_DEFAULT);
    end else if (cfg.depth_request > DEPTH_MAX) begin
      bits = 4'(DEPTH_MAX);
    end else begin
      bits = 4'(cfg.depth_request);
    end
  end

  always_comb begin
    q_job.sample = in_sample;
    q_job.bayer  = bayer_at(pos_row, 3'(pos_col));
    q_job.bits   = bits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      ch_r  <= '0;
      row_r <= '0;
    end else if (q_push) begin
      col_r <= col_nxt;
      ch_r  <= ch_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/bodq_queue.sv
// ----------------------------------------------------------------------------
// bodq_queue - two-entry job queue
// Decouples the front end from the back end so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module bodq_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bodq_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output bodq_pkg::job_t head_job
);
  import bodq_pkg::*;

  job_t       store_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full     = (count_r == 2'd2);
  assign avail    = (count_r != 2'd0);
  assign head_job = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

>>> src/bodq_back.sv
// ----------------------------------------------------------------------------
// bodq_back - quantiser datapath
// Stage 1: clamp, scale, add dither bias, floor and clamp to the level range.
// Stage 2: normalise the level to Q0.16 and hold it in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bodq_back #(
  parameter int SAMPLE_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              job_avail,
  input  bodq_pkg::job_t                    job,
  output logic                              job_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bodq_pkg::LEVEL_W-1:0]      out_level,
  output logic [bodq_pkg::NORM_W-1:0]       out_normalized
);
  import bodq_pkg::*;

  localparam int F    = SAMPLE_FRAC_BITS;
  localparam int SXW  = (F + 2 > SAMPLE_W) ? F + 2 : SAMPLE_W;
  localparam int CLW  = F + 1;
  localparam int SUMW = F + 10;
  localparam int QW   = SUMW - F;
  localparam logic signed [SXW-1:0] ONE_X = SXW'(64'd1 << F);

  logic signed [SXW-1:0]  s_ext;
  logic [CLW-1:0]         s_cl;
  logic [SUMW-1:0]        scaled;
  logic signed [7:0]      bias8;
  logic signed [SUMW-1:0] bias_x, sum;
  logic [QW-1:0]          q;
  logic [LEVEL_W-1:0]     maxlev, lev;
  logic                   adv, s1_load;
  logic [39:0]            prod;

  logic                   s1_v_r;
  logic [LEVEL_W-1:0]     s1_level_r;
  logic [3:0]             s1_bits_r;
  logic                   out_v_r;
  logic [LEVEL_W-1:0]     out_level_r;
  logic [NORM_W-1:0]      out_norm_r;

  assign adv     = !out_v_r || out_ready;
  assign s1_load = !s1_v_r || adv;
  assign job_pop = job_avail && s1_load;

  always_comb begin
    s_ext = SXW'(job.sample);
    priority if (s_ext < 0) begin
      s_cl = '0;
    end else if (s_ext > ONE_X) begin
      s_cl = CLW'(ONE_X);
    end else begin
      s_cl = CLW'(s_ext);
    end
    scaled = SUMW'(s_cl) << job.bits;
    // bias (2B - 63) / 128 of one output level, in Q.F units
    bias8  = $signed({1'b0, job.bayer, 1'b0}) - 8'sd63;
    bias_x = SUMW'(bias8) <<< (F - 7);
    sum    = $signed(scaled) + bias_x;
    q      = sum[SUMW-1:F];
    maxlev = 8'((9'd1 << job.bits) - 9'd1);
    priority if (sum[SUMW-1]) begin
      lev = '0;
    end else if (q > QW'(maxlev)) begin
      lev = maxlev;
    end else begin
      lev = q[LEVEL_W-1:0];
    end
  end

  assign prod = 40'(s1_level_r) * 40'(norm_recip(s1_bits_r));

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_level_r <= lev;
      s1_bits_r  <= job.bits;
    end
    if (adv) begin
      out_level_r <= s1_level_r;
      out_norm_r  <= prod[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_v_r <= job_avail;
      end
      if (adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  assign out_valid      = out_v_r;
  assign out_level      = out_level_r;
  assign out_normalized = out_norm_r;

endmodule

`default_nettype wire

>>> src/bayer_ordered_dither_quantizer.sv
// ----------------------------------------------------------------------------
// bayer_ordered_dither_quantizer - 8x8 Bayer ordered dither quantiser
//
// in_ch carries interleaved Q2.16 samples in raster order with a frame_start
// flag; out_ch returns, per sample, the quantised level and that level as
// unsigned Q0.16. The cfg port writes depth request (index 0), row width (1)
// and channel count (2); write only while no beat is in flight.
// One sample is taken per clock while the queue is not full. On the way
// to out_ch the front end classifies each beat into a two-entry queue,
// back stage 1 forms the level, back stage 2 the normalised value in the
// output register.
// When out_ch stalls, the back pipeline holds and fills its bubbles; in_ch
// keeps accepting until the queue is full, so up to four beats are buffered.
// Reset (synchronous, active low) empties the pipeline, zeroes the position
// counters and loads depth 6, row width 1 and one channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bayer_ordered_dither_quantizer #(
  parameter int SAMPLE_FRAC_BITS = 16,
  parameter int MAX_WIDTH        = 65535,
  parameter int MAX_CHANNELS     = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bodq_stream_if.sink                 in_ch,
  bodq_stream_if.source               out_ch,
  input  logic                        cfg_we,
  input  bodq_pkg::cfg_idx_t          cfg_index,
  input  logic [bodq_pkg::CFG_W-1:0]  cfg_data
);
  import bodq_pkg::*;

  cfg_t cfg_r;
  job_t push_job, head_job;
  logic q_push, q_full, q_avail, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_request <= DEPTH_DEFAULT;
      cfg_r.row_width     <= 16'd1;
      cfg_r.channel_count <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEPTH:    cfg_r.depth_request <= cfg_data[4:0];
        CFG_ROW:      cfg_r.row_width     <= cfg_data[15:0];
        CFG_CHANNELS: cfg_r.channel_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  bodq_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_sample      (in_ch.data.sample),
    .in_frame_start (in_ch.data.frame_start),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  bodq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head_job (head_job)
  );

  bodq_back #(
    .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_avail      (q_avail),
    .job            (head_job),
    .job_pop        (q_pop),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_level      (out_ch.data.level),
    .out_normalized (out_ch.data.normalized)
  );

endmodule

`default_nettype wire

>>> src/bodq_checker.sv
// ----------------------------------------------------------------------------
// bodq_checker - port-level checks for the dither quantiser
// Watches the stream and reset behaviour seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bodq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bodq_pkg::LEVEL_W-1:0]  out_level,
  input logic [bodq_pkg::NORM_W-1:0]   out_normalized
);
  import bodq_pkg::*;

  logic       in_beat, out_beat;
  logic [2:0] pending_r;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 3'd0;
    end else begin
      pending_r <= pending_r + 3'(in_beat) - 3'(out_beat);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_normalized))
    else $error("result beat changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat |-> pending_r != 3'd0)
    else $error("result beat without a matching sample");

  a_buffer_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'd4)
    else $error("more samples in flight than the pipeline holds");

  a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_level == '0 |-> out_normalized == '0)
    else $error("zero level with non-zero normalised value");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind bayer_ordered_dither_quantizer bodq_checker u_bodq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_level      (out_ch.data.level),
  .out_normalized (out_ch.data.normalized)
);

`default_nettype wire

>>> dv/bodq_dither_checker.sv
// ----------------------------------------------------------------------------
// bodq_dither_checker - scoreboard for the ordered dither quantiser
// Follows register writes and accepted input beats, predicts level and
// normalised value for each sample, and compares result beats in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bodq_dither_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  bodq_pkg::in_beat_t         in_beat,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  bodq_pkg::out_beat_t        out_beat,
  input  logic                       cfg_we,
  input  bodq_pkg::cfg_idx_t         cfg_index,
  input  logic [bodq_pkg::CFG_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending,
  output int                         checked,
  output logic [8:1]                 depths_seen
);
  import bodq_pkg::*;

  // 8x8 threshold matrix, row-major
  localparam logic [5:0] THRESHOLD [64] = '{
    6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
    6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
    6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
    6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
    6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
    6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
    6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
    6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
  };

  logic [4:0]  depth_req;
  logic [15:0] row_w;
  logic [3:0]  chans;
  int          col_pos;
  int          row_pos;
  int          chan_pos;
  int          fails;
  int          checks;
  logic [8:1]  depth_mask;
  out_beat_t   quantised_q[$];

  function automatic out_beat_t quantise_sample(input in_beat_t beat);
    longint    s;
    longint    acc;
    int        bits;
    int        maxlev;
    int        lev;
    int        tap;
    int        row_lim;
    int        chan_lim;
    out_beat_t r;
    if (beat.frame_start) begin
      col_pos  = 0;
      row_pos  = 0;
      chan_pos = 0;
    end
    bits = (depth_req == 5'd0) ? 6 : ((depth_req > 5'd8) ? 8 : int'(depth_req));
    depth_mask[bits] = 1'b1;
    maxlev = (1 << bits) - 1;
    s = longint'($signed(beat.sample));
    if (s < 0) s = 0;
    if (s > 65536) s = 65536;
    tap = int'(THRESHOLD[(row_pos % 8) * 8 + (col_pos % 8)]);
    // bias is (2t-63)/128 of one LSB of the output, in Q.16 units
    acc = (s << bits) + longint'(2 * tap - 63) * 512;
    if (acc < 0) lev = 0;
    else if ((acc >> 16) > maxlev) lev = maxlev;
    else lev = int'(acc >> 16);
    r.level      = 8'(lev);
    r.normalized = 16'((longint'(lev) * 65535) / maxlev);
    // zero limits count as one; a counter past a lowered limit wraps next time
    row_lim  = (row_w == 16'd0) ? 1 : int'(row_w);
    chan_lim = (chans == 4'd0) ? 1 : ((chans > 4'd8) ? 8 : int'(chans));
    chan_pos++;
    if (chan_pos >= chan_lim) begin
      chan_pos = 0;
      col_pos++;
      if (col_pos >= row_lim) begin
        col_pos = 0;
        row_pos = (row_pos + 1) % 8;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      depth_req  = 5'd6;
      row_w      = 16'd1;
      chans      = 4'd1;
      col_pos    = 0;
      row_pos    = 0;
      chan_pos   = 0;
      fails      = 0;
      checks     = 0;
      depth_mask = '0;
      quantised_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEPTH:    depth_req = cfg_data[4:0];
          CFG_ROW:      row_w     = cfg_data[15:0];
          CFG_CHANNELS: chans     = cfg_data[3:0];
          default:      ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (quantised_q.size() == 0) begin
          $error("unexpected result beat: level %0d normalized %0d",
                 out_beat.level, out_beat.normalized);
          fails++;
        end else begin
          want = quantised_q.pop_front();
          if (out_beat.level !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, out_beat.level);
            fails++;
          end
          if (out_beat.normalized !== want.normalized) begin
            $error("normalized: expected %0d, got %0d", want.normalized,
                   out_beat.normalized);
            fails++;
          end
          checks++;
        end
      end
      if (in_valid && in_ready) quantised_q.push_back(quantise_sample(in_beat));
    end
    fail_count  <= fails;
    pending     <= quantised_q.size();
    checked     <= checks;
    depths_seen <= depth_mask;
  end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench - top level for the ordered dither quantiser
// Drives sample beats and register writes, throttles the result channel,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bodq_pkg::*;

  localparam cfg_idx_t CFG_SPARE      = 2'd3;
  localparam int       RANDOM_PHASES  = 12;
  localparam int       PHASE_BEATS    = 100;
  localparam int       HOLD_OFF_CYCLES = 200;
  localparam int       SETTLE_CYCLES  = 6;
  localparam int       WATCHDOG_LIMIT = 5000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we;
  cfg_idx_t         cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int         fail_count;
  int         pending;
  int         checked;
  logic [8:1] depths_seen;
  int         beats_sent = 0;
  int         settings_run = 0;
  int         idle_cycles = 0;
  bit         hold_off_req = 1'b0;

  bodq_stream_if #(.payload_t(in_beat_t))  in_ch ();
  bodq_stream_if #(.payload_t(out_beat_t)) out_ch ();

  bayer_ordered_dither_quantizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bodq_dither_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_beat     (in_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_beat    (out_ch.data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .depths_seen (depths_seen)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 18'($urandom_range(0, 65536));
    if (r < 65) begin
      if ($urandom_range(0, 1) == 1) return 18'($urandom_range(0, 16));
      return 18'($urandom_range(65520, 65536));
    end
    if (r < 85) return 18'($urandom);
    return {1'b1, 17'($urandom)};
  endfunction

  task automatic send_beat(input logic [SAMPLE_W-1:0] value, input logic fs,
                           input bit steady);
    in_beat_t b;
    int       gap;
    b.sample      = value;
    b.frame_start = fs;
    gap = pick_gap(steady);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  // let every beat in flight come out before touching registers
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ready window that gives way at once to a hold-off request
  task automatic ready_window(input int n);
    for (int k = 0; k < n; k++) begin
      if (hold_off_req) break;
      @(posedge clk);
    end
  endtask

  task automatic program_regs(input logic [15:0] depth_word, input logic [15:0] row_word,
                              input logic [15:0] chan_word, input bit poke_spare);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEPTH;
    cfg_data  <= depth_word;
    @(posedge clk);
    cfg_index <= CFG_ROW;
    cfg_data  <= row_word;
    @(posedge clk);
    cfg_index <= CFG_CHANNELS;
    cfg_data  <= chan_word;
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= CFG_SPARE;
      cfg_data  <= 16'hFFFF;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  task automatic random_settings(output logic [15:0] depth_word,
                                 output logic [15:0] row_word,
                                 output logic [15:0] chan_word);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) depth_word = {11'($urandom), 5'($urandom_range(1, 8))};
    else if (r < 80) depth_word = {11'($urandom), 5'd0};
    else depth_word = {11'($urandom), 5'($urandom_range(9, 31))};
    r = $urandom_range(0, 99);
    if (r < 60) row_word = 16'($urandom_range(1, 8));
    else if (r < 85) row_word = 16'($urandom_range(9, 40));
    else if (r < 92) row_word = 16'd0;
    else row_word = 16'($urandom_range(41, 65535));
    r = $urandom_range(0, 99);
    if (r < 70) chan_word = {12'($urandom), 4'($urandom_range(1, 4))};
    else if (r < 85) chan_word = {12'($urandom), 4'($urandom_range(5, 8))};
    else if (r < 92) chan_word = {12'($urandom), 4'd0};
    else chan_word = {12'($urandom), 4'($urandom_range(9, 15))};
  endtask

  // result side: short stalls, long stalls, stretches of steady ready, one hold-off
  initial begin
    int r;
    out_ch.ready <= 1'b0;
    repeat (10) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_ch.ready <= 1'b1;
          ready_window($urandom_range(1, 20));
        end else if (r < 85) begin
          out_ch.ready <= 1'b0;
          ready_window($urandom_range(1, 3));
        end else if (r < 95) begin
          out_ch.ready <= 1'b0;
          ready_window($urandom_range(4, 40));
        end else begin
          out_ch.ready <= 1'b1;
          ready_window(100);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("[bayer_ordered_dither_quantizer] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [15:0] depth_word;
    logic [15:0] row_word;
    logic [15:0] chan_word;
    bit          steady;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_DEPTH;
    cfg_data    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: depth 6, one pixel per row, one channel
    send_beat(18'd0, 1'b1, 1'b0);
    send_beat(18'd65536, 1'b0, 1'b0);
    send_beat(18'h20000, 1'b0, 1'b0);
    send_beat(18'h1FFFF, 1'b0, 1'b0);
    drain();

    // depth request masked down to zero, spare index written
    program_regs(16'hFFE0, 16'd3, 16'd2, 1'b1);
    send_beat(18'd65535, 1'b0, 1'b0);
    send_beat(18'd1, 1'b0, 1'b0);
    send_beat(18'd32768, 1'b0, 1'b0);
    send_beat(18'h3FFFF, 1'b0, 1'b0);
    send_beat(18'd65536, 1'b1, 1'b0);
    send_beat(18'd16384, 1'b0, 1'b0);
    send_beat(18'd49152, 1'b0, 1'b0);
    send_beat(18'd65537, 1'b0, 1'b0);
    drain();

    // zero width and zero channels act as one; depth 31 caps at 8
    program_regs(16'd31, 16'd0, 16'd0, 1'b0);
    send_beat(18'd32768, 1'b0, 1'b0);
    send_beat(18'd128, 1'b0, 1'b0);
    send_beat(18'd65408, 1'b0, 1'b0);
    send_beat(18'h2AAAA, 1'b0, 1'b0);
    drain();

    // channel count above eight, then a mid-row change without frame start
    program_regs(16'd9, 16'd2, 16'hFFFF, 1'b0);
    repeat (5) send_beat(18'(16'h5555), 1'b0, 1'b0);
    drain();
    program_regs(16'd1, 16'd1, 16'd1, 1'b0);
    send_beat(18'd32767, 1'b0, 1'b0);
    send_beat(18'd32768, 1'b0, 1'b0);
    send_beat(18'd49152, 1'b0, 1'b0);
    send_beat(18'd0, 1'b0, 1'b0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        depth_word = 16'd8;
        row_word   = 16'd65535;
        chan_word  = 16'd8;
      end else if (p == 1) begin
        depth_word = 16'd1;
        row_word   = 16'd1;
        chan_word  = 16'd1;
      end else begin
        random_settings(depth_word, row_word, chan_word);
      end
      program_regs(depth_word, row_word, chan_word, p == 2);
      // phase 1 keeps the input busy while the result side holds off
      if (p == 1) hold_off_req = 1'b1;
      steady = (p == 1) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        send_beat(rand_sample(),
                  (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 49) == 0),
                  steady);
      end
      drain();
    end

    $display("covered %0d samples, %0d results checked, %0d register settings",
             beats_sent, checked, settings_run);
    $display("effective depths exercised (bit n = depth n): %b", depths_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[bayer_ordered_dither_quantizer] OK");
    end else begin
      $display("[bayer_ordered_dither_quantizer] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/bodq_pkg.sv
src/bodq_stream_if.sv
src/bodq_front.sv
src/bodq_queue.sv
src/bodq_back.sv
src/bayer_ordered_dither_quantizer.sv
src/bodq_checker.sv
dv/bodq_dither_checker.sv
dv/testbench.sv
